FILE: rtl/core/oakt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oakt_pkg
// shared widths, codes, entry layout and key mix for the key table
// ----------------------------------------------------------------------------
package oakt_pkg;

    localparam int DEFAULT_SLOTS = 128;

    localparam int ACTION_W    = 2;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 7;
    localparam int COUNT_OUT_W = 8;
    localparam int FILL_W      = 7;

    localparam logic [FILL_W-1:0] FILL_RESET = 7'd90;

    // s_tdata: action, key, value, zero pad to whole bytes
    localparam int IN_FIELDS_W = ACTION_W + KEY_W + VALUE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // m_tdata: status, slot, value_out, count, zero pad to whole bytes
    localparam int OUT_FIELDS_W = STATUS_W + SLOT_OUT_W + VALUE_W + COUNT_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // table entry: {valid, value, key}
    localparam int ENTRY_W     = 1 + VALUE_W + KEY_W;
    localparam int ENTRY_VALID = ENTRY_W - 1;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    localparam logic [31:0] MIX_SEL  = 32'h7F37F773;
    localparam logic [31:0] MIX_HIGH = 32'hF0F0F0F0;
    localparam logic [31:0] MIX_LOW  = 32'h0F0F0F0F;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // rotate/mask/xor mix of the key, before reduction to a slot
    function automatic logic [31:0] mix_key(input logic [KEY_W-1:0] k);
        logic [31:0] h;
        logic [31:0] r;
        h = (rotr32(k, 7) & MIX_SEL) | (rotr32(k, 13) & ~MIX_SEL);
        h = h ^ ((rotr32(k, 8) & MIX_HIGH) | (rotr32(k, 16) & MIX_LOW));
        r = rotr32(h, 21);
        h = h ^ r;
        r = rotr32(r, 13);
        h = h ^ r;
        r = rotr32(r, 3);
        h = h ^ r;
        return h;
    endfunction

endpackage

FILE: rtl/core/oakt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oakt_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oakt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/oakt_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oakt_hash
// home slot of a key: key mix reduced modulo the slot count
// ----------------------------------------------------------------------------
module oakt_hash #(
    parameter int SLOTS = oakt_pkg::DEFAULT_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [oakt_pkg::KEY_W-1:0]   key,
    output logic                         done,
    output logic [$clog2(SLOTS)-1:0]     home
);

    import oakt_pkg::*;

    localparam int  IDX_W  = $clog2(SLOTS);
    localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    // full mix of the incoming key
    logic [31:0] mixed;

    assign mixed = mix_key(key);

    generate
        if (IS_POW2)
        begin : g_mask
            // power of two: the remainder is the low bits
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                    home_reg <= '0;
                end
                else
                begin
                    done_reg <= start;
                    if (start)
                    begin
                        home_reg <= mixed[IDX_W-1:0];
                    end
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else
        begin : g_recip
            // quotient estimate by reciprocal multiply, low by at most one,
            // then one compare and subtract; each step ends in a register
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

            logic             v1_reg;
            logic             v2_reg;
            logic             v3_reg;
            logic             done_reg;
            logic [31:0]      mix_reg;
            logic [31:0]      quot_reg;
            logic [IDX_W:0]   rem_reg;
            logic [IDX_W-1:0] home_reg;
            logic [63:0]      prod;
            logic [31:0]      diff;
            logic [IDX_W:0]   rem_sub;
            logic [IDX_W-1:0] home_next;

            always_comb
            begin
                prod      = 64'(mix_reg) * 64'(RECIP);
                diff      = mix_reg - quot_reg * 32'(SLOTS);
                rem_sub   = rem_reg - (IDX_W + 1)'(SLOTS);
                home_next = (rem_reg >= (IDX_W + 1)'(SLOTS)) ? rem_sub[IDX_W-1:0]
                                                             : rem_reg[IDX_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v1_reg   <= 1'b0;
                    v2_reg   <= 1'b0;
                    v3_reg   <= 1'b0;
                    done_reg <= 1'b0;
                    mix_reg  <= '0;
                    quot_reg <= '0;
                    rem_reg  <= '0;
                    home_reg <= '0;
                end
                else
                begin
                    v1_reg   <= start;
                    v2_reg   <= v1_reg;
                    v3_reg   <= v2_reg;
                    done_reg <= v3_reg;
                    if (start)
                    begin
                        mix_reg <= mixed;
                    end
                    if (v1_reg)
                    begin
                        quot_reg <= prod[63:32];
                    end
                    if (v2_reg)
                    begin
                        rem_reg <= diff[IDX_W:0];
                    end
                    if (v3_reg)
                    begin
                        home_reg <= home_next;
                    end
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
    endgenerate

endmodule

FILE: rtl/core/open_addressing_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_key_table
// hash table of 32-bit keys to nonzero 32-bit value handles, probed
// outward from the home slot in both directions, entries held in one ram
// ----------------------------------------------------------------------------
// sequence: hash of the key, then one ram read per probed slot, up to SLOTS-1
//   probes (when SLOTS is not a power of two the hash also registers quotient and
//   remainder); refused requests go from idle straight to the finish state
// throughput: one request at a time, the next taken the cycle after the result loads
// reset: a clearing pass writes every ram entry invalid while no request is
//   taken; count clears, fill limit returns to 90
// ----------------------------------------------------------------------------
module open_addressing_key_table #(
    parameter int SLOTS = oakt_pkg::DEFAULT_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // fill limit register write
    input  logic                            cfg_we,
    input  logic [oakt_pkg::FILL_W-1:0]     cfg_wdata,     // max_fill_percent
    // request side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [oakt_pkg::IN_TDATA_W-1:0] s_tdata,       // action, key, value
    // result side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [oakt_pkg::OUT_TDATA_W-1:0] m_tdata       // status, slot, value_out, count
);

    import oakt_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PROBES = 1 + 2 * (SLOTS / 2 - 1);
    localparam int PRB_W  = $clog2(PROBES + 1);
    localparam int LIM_W  = CNT_W + FILL_W;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // wraparound step of a slot index
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - IDX_W'(1);
    endfunction

    // request fields
    logic [ACTION_W-1:0] in_action;
    logic [KEY_W-1:0]    in_key;
    logic [VALUE_W-1:0]  in_value;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_key    = s_tdata[ACTION_W +: KEY_W];
    assign in_value  = s_tdata[ACTION_W + KEY_W +: VALUE_W];

    state_t                 state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       clr_reg, clr_next;
    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]       fwd_reg, fwd_next;
    logic [IDX_W-1:0]       bwd_reg, bwd_next;
    logic                   dir_reg, dir_next;      // next probe goes forward
    logic [IDX_W-1:0]       chk_reg, chk_next;      // slot of the read in flight
    logic [PRB_W-1:0]       issued_reg, issued_next;
    status_t                res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [CNT_W-1:0]       res_count_reg, res_count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // hash unit
    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_home;

    // entry ram
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    logic               hit;

    // fill limit: count*100 against SLOTS*percent
    logic [LIM_W-1:0] count_x100;
    logic [LIM_W-1:0] fill_limit;
    logic             over_fill;

    assign count_x100 = (LIM_W'(count_reg) << 6) + (LIM_W'(count_reg) << 5)
                      + (LIM_W'(count_reg) << 2);
    assign fill_limit = LIM_W'(SLOTS) * LIM_W'(fill_reg);
    assign over_fill  = (count_x100 > fill_limit);

    assign rd_valid = rd_data[ENTRY_VALID];
    assign rd_value = rd_data[KEY_W +: VALUE_W];
    assign rd_key   = rd_data[KEY_W-1:0];

    // add wants a free slot, lookup and delete a matching one
    assign hit = (act_reg == ACT_ADD) ? !rd_valid : (rd_valid && (rd_key == key_reg));

    oakt_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (in_key),
        .done  (hash_done),
        .home  (hash_home)
    );

    oakt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        fwd_next        = fwd_reg;
        bwd_next        = bwd_reg;
        dir_next        = dir_reg;
        chk_next        = chk_reg;
        issued_next     = issued_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        res_count_next  = res_count_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        hash_start = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = chk_reg;
        wr_data    = '0;
        rd_addr    = dir_reg ? fwd_reg : bwd_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // invalidate one entry per cycle
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next        = in_action;
                    key_next        = in_key;
                    val_next        = in_value;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    res_count_next  = count_reg;
                    unique case (in_action) inside
                        ACT_ADD:
                        begin
                            if (in_value == '0)
                            begin
                                res_status_next = ST_ZERO;
                                state_next      = S_FINISH;
                            end
                            else if (over_fill)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        ACT_LOOKUP, ACT_DELETE:
                        begin
                            hash_start = 1'b1;
                            state_next = S_HASH;
                        end
                        default:
                        begin
                            // unused action code: no change, reported as missing
                            res_status_next = ST_MISSING;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    // first read at home, then alternate +i / -i
                    rd_addr     = hash_home;
                    chk_next    = hash_home;
                    issued_next = PRB_W'(1);
                    fwd_next    = slot_inc(hash_home);
                    bwd_next    = slot_dec(hash_home);
                    dir_next    = 1'b1;
                    state_next  = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // one read issued per cycle, checked in the cycle after
                if (hit)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = chk_reg;
                    res_value_next  = '0;
                    res_count_next  = count_reg;
                    if (act_reg == ACT_ADD)
                    begin
                        wr_en          = 1'b1;
                        wr_data        = {1'b1, val_reg, key_reg};
                        count_next     = count_reg + CNT_W'(1);
                        res_count_next = count_reg + CNT_W'(1);
                    end
                    else if (act_reg == ACT_DELETE)
                    begin
                        wr_en = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_value_next = rd_value;
                    end
                    state_next = S_FINISH;
                end
                else if (issued_reg == PRB_W'(PROBES))
                begin
                    // probe sequence exhausted
                    res_status_next = (act_reg == ACT_ADD) ? ST_FULL : ST_MISSING;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    res_count_next  = count_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    chk_next    = dir_reg ? fwd_reg : bwd_reg;
                    issued_next = issued_reg + PRB_W'(1);
                    dir_next    = !dir_reg;
                    if (dir_reg)
                    begin
                        fwd_next = slot_inc(fwd_reg);
                    end
                    else
                    begin
                        bwd_next = slot_dec(bwd_reg);
                    end
                end
            end

            S_FINISH:
            begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({COUNT_OUT_W'(res_count_reg),
                                                 res_value_reg,
                                                 SLOT_OUT_W'(res_slot_reg),
                                                 res_status_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            fill_reg       <= FILL_RESET;
            count_reg      <= '0;
            clr_reg        <= '0;
            act_reg        <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            fwd_reg        <= '0;
            bwd_reg        <= '0;
            dir_reg        <= 1'b0;
            chk_reg        <= '0;
            issued_reg     <= '0;
            res_status_reg <= ST_OK;
            res_slot_reg   <= '0;
            res_value_reg  <= '0;
            res_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            fwd_reg        <= fwd_next;
            bwd_reg        <= bwd_next;
            dir_reg        <= dir_next;
            chk_reg        <= chk_next;
            issued_reg     <= issued_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_value_reg  <= res_value_next;
            res_count_reg  <= res_count_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
            if (cfg_we)
            begin
                fill_reg <= cfg_wdata;
            end
        end
    end

    // a request is taken whenever the table is idle, even with a result pending
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
